@@ design/page_replacement_fifo_lru_clock_assert.svh @@
// ---------------------------------------------------------------------------
// Page replacement unit: assertion macros
// Shared helpers that wrap concurrent assertions on the block clock and the
// active-low synchronous reset.
// ---------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_FIFO_LRU_CLOCK_ASSERT_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_CLOCK_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define PRC_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define PRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/prc_pkg.sv @@
// ---------------------------------------------------------------------------
// Page replacement unit: package
// Word types, register indexes, policy and operation codes shared by the
// frame table, the sequencer and the top level.
// ---------------------------------------------------------------------------
package prc_pkg;

    // Default sizes
    localparam int MAX_FRAMES_DEF = 32;
    localparam int PAGE_BITS_DEF  = 16;

    // Fixed field widths of the words on the ports
    localparam int PAGE_W     = 16;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 6;
    localparam int POL_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = CFG_IDX_W'(1);

    // Replacement policies; the unused code behaves as FIFO
    localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
    localparam logic [POL_W-1:0] POL_LRU   = 2'd1;
    localparam logic [POL_W-1:0] POL_CLOCK = 2'd2;

    // Input operations
    localparam logic OP_REF   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Frame count after reset
    localparam logic [CFG_DATA_W-1:0] FRAMES_RST = CFG_DATA_W'(2);

    typedef struct packed {
        logic              op;
        logic [PAGE_W-1:0] page;
    } t_in_word;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  frame_index;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [CNT_W-1:0]  fault_count;
    } t_out_word;

    // Frame table write controls
    typedef struct packed {
        logic clear;
        logic page_we;
        logic stamp_we;
        logic used_set;
        logic used_clr;
    } t_tbl_ctl;

endpackage

@@ design/prc_table.sv @@
// ---------------------------------------------------------------------------
// Page replacement unit: frame table
// Page and stamp memories with one registered read port and one write port,
// plus valid, used and stamp-written bits held in flops.
// ---------------------------------------------------------------------------
module prc_table #(
    parameter int MAX_FRAMES = prc_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = prc_pkg::PAGE_BITS_DEF,
    parameter int FW         = $clog2(MAX_FRAMES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prc_pkg::t_tbl_ctl            i_ctl,
    input  logic [FW-1:0]                i_wr_addr,
    input  logic [PAGE_BITS-1:0]         i_wr_page,
    input  logic [prc_pkg::STAMP_W-1:0]  i_wr_stamp,
    input  logic [FW-1:0]                i_rd_addr,
    input  logic [FW-1:0]                i_used_addr,
    output logic                         o_rd_valid,
    output logic [PAGE_BITS-1:0]         o_rd_page,
    output logic [prc_pkg::STAMP_W-1:0]  o_rd_stamp,
    output logic                         o_used
);
    import prc_pkg::*;

    logic [PAGE_BITS-1:0] r_mem_page  [MAX_FRAMES];
    logic [STAMP_W-1:0]   r_mem_stamp [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [MAX_FRAMES-1:0] r_used;
    logic [MAX_FRAMES-1:0] r_stamp_ok;
    logic [PAGE_BITS-1:0] r_rd_page;
    logic [STAMP_W-1:0]   r_rd_stamp;
    logic                 r_rd_valid;
    logic                 r_rd_ok;

    // Per-frame flags: clear all at once, set or drop one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_used     <= '0;
            r_stamp_ok <= '0;
        end else if (i_ctl.clear) begin
            r_valid    <= '0;
            r_used     <= '0;
            r_stamp_ok <= '0;
        end else begin
            if (i_ctl.page_we) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.stamp_we) begin
                r_stamp_ok[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.used_set) begin
                r_used[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.used_clr) begin
                r_used[i_wr_addr] <= 1'b0;
            end
        end
    end

    // Memories: write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_ctl.page_we) begin
            r_mem_page[i_wr_addr] <= i_wr_page;
        end
        if (i_ctl.stamp_we) begin
            r_mem_stamp[i_wr_addr] <= i_wr_stamp;
        end
        r_rd_page  <= r_mem_page[i_rd_addr];
        r_rd_stamp <= r_mem_stamp[i_rd_addr];
        r_rd_valid <= r_valid[i_rd_addr];
        r_rd_ok    <= r_stamp_ok[i_rd_addr];
    end

    // A stamp never written since clear reads as zero
    assign o_rd_valid = r_rd_valid;
    assign o_rd_page  = r_rd_page;
    assign o_rd_stamp = r_rd_ok ? r_rd_stamp : '0;
    assign o_used     = r_used[i_used_addr];

endmodule

@@ design/prc_ctrl.sv @@
// ---------------------------------------------------------------------------
// Page replacement unit: sequencer
// Walks the frame table one frame per cycle through a single compare unit:
// hit search and least-stamp search together, then the clock sweep, then
// the eviction read and the table update.
// ---------------------------------------------------------------------------
`include "page_replacement_fifo_lru_clock_assert.svh"

module prc_ctrl #(
    parameter int MAX_FRAMES = prc_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = prc_pkg::PAGE_BITS_DEF,
    parameter int FW         = $clog2(MAX_FRAMES)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  prc_pkg::t_in_word               i_in_data,
    input  logic [prc_pkg::POL_W-1:0]       i_policy,
    input  logic [prc_pkg::CFG_DATA_W-1:0]  i_frame_count,
    input  logic                            i_res_free,
    output logic                            o_res_valid,
    output prc_pkg::t_out_word              o_res,
    output prc_pkg::t_tbl_ctl               o_tbl_ctl,
    output logic [FW-1:0]                   o_wr_addr,
    output logic [PAGE_BITS-1:0]            o_wr_page,
    output logic [prc_pkg::STAMP_W-1:0]     o_wr_stamp,
    output logic [FW-1:0]                   o_rd_addr,
    output logic [FW-1:0]                   o_used_addr,
    input  logic                            i_rd_valid,
    input  logic [PAGE_BITS-1:0]            i_rd_page,
    input  logic [prc_pkg::STAMP_W-1:0]     i_rd_stamp,
    input  logic                            i_used
);
    import prc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SWEEP = 6'b000100,
        S_EVRD  = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state              r_state,     n_state;
    logic [FW-1:0]       r_idx,       n_idx;
    logic [FW-1:0]       r_cmp_idx,   n_cmp_idx;
    logic                r_cmp_vld,   n_cmp_vld;
    logic [FW-1:0]       r_min_idx,   n_min_idx;
    logic [STAMP_W-1:0]  r_min_stamp, n_min_stamp;
    logic [FW-1:0]       r_victim,    n_victim;
    logic                r_hit,       n_hit;
    logic                r_ev_valid,  n_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page,  n_ev_page;
    logic [FW-1:0]       r_ptr,       n_ptr;
    logic [FW-1:0]       r_last,      n_last;
    logic [PAGE_BITS-1:0] r_page,     n_page;
    logic [STAMP_W-1:0]  r_stamp_now, n_stamp_now;
    logic [STAMP_W-1:0]  r_refclk,    n_refclk;
    logic [CNT_W-1:0]    r_faults,    n_faults;
    logic                r_is_lru,    n_is_lru;
    logic                r_is_clk,    n_is_clk;

    logic [FW-1:0]       w_last;
    logic [FW-1:0]       w_ptr_adv;
    logic                w_le;
    logic [FW-1:0]       w_min_idx;
    logic [STAMP_W-1:0]  w_min_stamp;
    logic                w_match;
    logic                w_clr_go;
    logic [CNT_W-1:0]    w_faults_inc;

    // Last usable frame from the configured count, clamped to at least two frames and to the table
    always_comb begin
        if (i_frame_count < CFG_DATA_W'(2)) begin
            w_last = FW'(1);
        end else if (32'(i_frame_count) > 32'(MAX_FRAMES)) begin
            w_last = FW'(MAX_FRAMES - 1);
        end else begin
            w_last = FW'(i_frame_count - CFG_DATA_W'(1));
        end
    end

    // Shared compare unit: page match and least-stamp update
    assign w_match     = i_rd_valid && (i_rd_page == r_page);
    assign w_le        = (i_rd_stamp <= r_min_stamp);
    assign w_min_idx   = w_le ? r_cmp_idx : r_min_idx;
    assign w_min_stamp = w_le ? i_rd_stamp : r_min_stamp;

    assign w_ptr_adv    = (r_ptr == r_last) ? '0 : r_ptr + 1'b1;
    assign w_faults_inc = (r_faults != '1) ? r_faults + CNT_W'(1) : r_faults;
    assign w_clr_go     = (r_state == S_IDLE) && i_in_valid && (i_in_data.op == OP_CLEAR);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_min_idx   = r_min_idx;
        n_min_stamp = r_min_stamp;
        n_victim    = r_victim;
        n_hit       = r_hit;
        n_ev_valid  = r_ev_valid;
        n_ev_page   = r_ev_page;
        n_ptr       = r_ptr;
        n_last      = r_last;
        n_page      = r_page;
        n_stamp_now = r_stamp_now;
        n_refclk    = r_refclk;
        n_faults    = r_faults;
        n_is_lru    = r_is_lru;
        n_is_clk    = r_is_clk;
        o_tbl_ctl   = '0;
        o_wr_addr   = r_victim;
        o_rd_addr   = (r_state == S_EVRD) ? r_victim : r_idx;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_data.op == OP_CLEAR) begin
                        // Empty the table and restart the counters
                        o_tbl_ctl.clear = 1'b1;
                        n_ptr      = '0;
                        n_refclk   = STAMP_W'(1);
                        n_faults   = '0;
                        n_hit      = 1'b0;
                        n_victim   = '0;
                        n_ev_valid = 1'b0;
                        n_ev_page  = '0;
                        n_state    = S_DONE;
                    end else begin
                        n_page      = PAGE_BITS'(i_in_data.page);
                        n_stamp_now = r_refclk;
                        n_refclk    = (r_refclk != '1) ? r_refclk + STAMP_W'(1) : r_refclk;
                        n_last      = w_last;
                        n_ptr       = (r_ptr > w_last) ? '0 : r_ptr;
                        n_idx       = '0;
                        n_cmp_vld   = 1'b0;
                        n_min_idx   = '0;
                        n_min_stamp = '1;
                        n_is_lru    = (i_policy == POL_LRU);
                        n_is_clk    = (i_policy == POL_CLOCK);
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read per cycle, compare the previous one
                n_idx     = r_idx + 1'b1;
                n_cmp_idx = r_idx;
                n_cmp_vld = 1'b1;
                if (r_cmp_vld) begin
                    if (w_match) begin
                        n_hit      = 1'b1;
                        n_victim   = r_cmp_idx;
                        n_ev_valid = 1'b0;
                        n_ev_page  = '0;
                        n_state    = S_WRITE;
                    end else begin
                        n_min_idx   = w_min_idx;
                        n_min_stamp = w_min_stamp;
                        if (r_cmp_idx == r_last) begin
                            n_hit    = 1'b0;
                            n_faults = w_faults_inc;
                            if (r_is_lru) begin
                                n_victim = w_min_idx;
                                n_state  = S_EVRD;
                            end else if (r_is_clk) begin
                                n_state = S_SWEEP;
                            end else begin
                                n_victim = r_ptr;
                                n_ptr    = w_ptr_adv;
                                n_state  = S_EVRD;
                            end
                        end
                    end
                end
            end
            S_SWEEP: begin
                // Drop used bits until a clear one comes under the hand
                o_wr_addr = r_ptr;
                n_ptr     = w_ptr_adv;
                if (i_used) begin
                    o_tbl_ctl.used_clr = 1'b1;
                end else begin
                    n_victim = r_ptr;
                    n_state  = S_EVRD;
                end
            end
            S_EVRD: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // Capture the evicted page, then place and mark the frame
                if (!r_hit) begin
                    o_tbl_ctl.page_we = 1'b1;
                    n_ev_valid = i_rd_valid;
                    n_ev_page  = i_rd_valid ? i_rd_page : '0;
                end
                o_tbl_ctl.stamp_we = r_is_lru;
                o_tbl_ctl.used_set = r_is_clk;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_wr_page   = r_page;
    assign o_wr_stamp  = r_stamp_now;
    assign o_used_addr = r_ptr;

    // Result word
    always_comb begin
        o_res.hit           = r_hit;
        o_res.frame_index   = IDX_W'(r_victim);
        o_res.evicted_valid = r_ev_valid;
        o_res.evicted_page  = PAGE_W'(r_ev_page);
        o_res.fault_count   = r_faults;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_ptr     <= '0;
            r_refclk  <= STAMP_W'(1);
            r_faults  <= '0;
            r_is_lru  <= 1'b0;
            r_is_clk  <= 1'b0;
            r_last    <= FW'(1);
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_ptr     <= n_ptr;
            r_refclk  <= n_refclk;
            r_faults  <= n_faults;
            r_is_lru  <= n_is_lru;
            r_is_clk  <= n_is_clk;
            r_last    <= n_last;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_min_idx   <= n_min_idx;
        r_min_stamp <= n_min_stamp;
        r_victim    <= n_victim;
        r_hit       <= n_hit;
        r_ev_valid  <= n_ev_valid;
        r_ev_page   <= n_ev_page;
        r_page      <= n_page;
        r_stamp_now <= n_stamp_now;
    end

    // Checks
    `PRC_ASSERT_HOLDS(a_ptr_range, i_clk, i_rst_n, r_state != S_IDLE, r_ptr <= r_last, "victim pointer beyond frame count")
    `PRC_ASSERT_HOLDS(a_hit_no_evict, i_clk, i_rst_n, (r_state == S_DONE) && r_hit, !r_ev_valid, "hit reports an eviction")
    `PRC_ASSERT_NEXT(a_faults_mono, i_clk, i_rst_n, !w_clr_go, r_faults >= $past(r_faults), "fault count went down without clear")
    `PRC_ASSERT_NEXT(a_sweep_moves, i_clk, i_rst_n, (r_state == S_SWEEP) && i_used, r_ptr != $past(r_ptr), "clock hand stuck on a used frame")

endmodule

@@ design/page_replacement_fifo_lru_clock.sv @@
// ---------------------------------------------------------------------------
// Page replacement unit: top level
// Frame table with FIFO, LRU and CLOCK replacement. Holds the configuration
// registers and the output word register.
// ---------------------------------------------------------------------------
//  channel | direction | words                       | handshake
//  in      | input     | op, page                    | i_in_valid / o_in_ready
//  out     | output    | hit, frame_index, evicted.. | o_out_valid / i_out_ready
//  cfg     | input     | index, data (policy, count) | i_cfg_valid / o_cfg_ready
//
//  A miss searches every frame in use for FIFO and LRU, one frame per cycle
//  through the table memory read port; a hit in frame h ends the search at
//  that frame. CLOCK adds a sweep of the hand to a miss. A clear goes straight
//  to the result word.
//  Synchronous active-low reset empties the table at once; no clearing pass.
//  The output register holds a finished word while the out side stalls; the
//  next word is accepted meanwhile and waits in the sequencer until it drains.
// ---------------------------------------------------------------------------
module page_replacement_fifo_lru_clock #(
    parameter int MAX_FRAMES = prc_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = prc_pkg::PAGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  prc_pkg::t_in_word               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output prc_pkg::t_out_word              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [prc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import prc_pkg::*;

    localparam int FW = $clog2(MAX_FRAMES);

    logic [POL_W-1:0]      r_policy;
    logic [CFG_DATA_W-1:0] r_frame_count;
    logic                  r_out_vld;
    t_out_word             r_out;

    logic                  w_out_free;
    logic                  w_res_vld;
    t_out_word             w_res;
    t_tbl_ctl              w_tbl_ctl;
    logic [FW-1:0]         w_wr_addr;
    logic [PAGE_BITS-1:0]  w_wr_page;
    logic [STAMP_W-1:0]    w_wr_stamp;
    logic [FW-1:0]         w_rd_addr;
    logic [FW-1:0]         w_used_addr;
    logic                  w_rd_valid;
    logic [PAGE_BITS-1:0]  w_rd_page;
    logic [STAMP_W-1:0]    w_rd_stamp;
    logic                  w_used;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy      <= POL_FIFO;
            r_frame_count <= FRAMES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_POLICY: r_policy      <= i_cfg_data[POL_W-1:0];
                CFG_FRAMES: r_frame_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output word register: load when empty or draining
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_vld) begin
            r_out <= w_res;
        end
    end

    prc_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .FW         (FW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_policy      (r_policy),
        .i_frame_count (r_frame_count),
        .i_res_free    (w_out_free),
        .o_res_valid   (w_res_vld),
        .o_res         (w_res),
        .o_tbl_ctl     (w_tbl_ctl),
        .o_wr_addr     (w_wr_addr),
        .o_wr_page     (w_wr_page),
        .o_wr_stamp    (w_wr_stamp),
        .o_rd_addr     (w_rd_addr),
        .o_used_addr   (w_used_addr),
        .i_rd_valid    (w_rd_valid),
        .i_rd_page     (w_rd_page),
        .i_rd_stamp    (w_rd_stamp),
        .i_used        (w_used)
    );

    prc_table #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .FW         (FW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_tbl_ctl),
        .i_wr_addr   (w_wr_addr),
        .i_wr_page   (w_wr_page),
        .i_wr_stamp  (w_wr_stamp),
        .i_rd_addr   (w_rd_addr),
        .i_used_addr (w_used_addr),
        .o_rd_valid  (w_rd_valid),
        .o_rd_page   (w_rd_page),
        .o_rd_stamp  (w_rd_stamp),
        .o_used      (w_used)
    );

endmodule
